// ----- hdl/gpd_pkg.sv -----
package gpd_pkg;

  localparam int SLOPE_BITS = 48;
  localparam int INDEX_BITS = 32;
  localparam int HOLD_BITS  = 11;
  localparam int RISE_BITS  = 12;
  localparam int LIMIT_BITS = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_FLOOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LIMIT = 2'd2;

  localparam logic [HOLD_BITS-1:0]  HOLD_RESET  = 11'd150;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 31'd459;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_AVG    = 5'b01000,
    ST_EMIT   = 5'b10000
  } gpd_state_t;

endpackage

// ----- hdl/gyro_peak_detector.sv -----
// Timing: an item that updates a slope goes from accept through DECIDE, DIV and AVG
// back to ready; one bit of the shared restoring divider per cycle is worked in DIV.
// Other items go through DECIDE only, and through AVG with a zero time step or EMIT
// with a peak; a peak's out_valid is registered in EMIT, after the DECIDE of the item that closes its region,
// later if out_stall holds. Reset is synchronous, active low: registers return to
// 0 / 150 / 459, tracking is cleared and the sample counter restarts at 0.
module gyro_peak_detector #(
  parameter int SAMPLE_BITS     = 16,
  parameter int TIME_BITS       = 32,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic        [TIME_BITS-1:0]            in_timestamp,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_peak_value,
  output logic        [TIME_BITS-1:0]            out_peak_time,
  output logic        [gpd_pkg::INDEX_BITS-1:0]  out_peak_index,
  input  logic                                   cfg_wr_en,
  input  logic        [gpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [gpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SB    = gpd_pkg::SLOPE_BITS;
  localparam int NUM_W = SAMPLE_BITS + 1 + SLOPE_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int EXT_W = ((NUM_W > SB) ? NUM_W : SB) + 1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SB-1:0] SL_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SL_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] SL_MAX_X = EXT_W'(SL_MAX);
  localparam logic signed [EXT_W-1:0] SL_MIN_X = EXT_W'(SL_MIN);

  function automatic logic signed [SAMPLE_BITS-1:0] neg_sat(
    input logic signed [SAMPLE_BITS-1:0] v
  );
    return (v == S_MIN) ? S_MAX : -v;
  endfunction

  gpd_pkg::gpd_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0]         peak_floor_r;
  logic [gpd_pkg::HOLD_BITS-1:0]         hold_count_r;
  logic [gpd_pkg::LIMIT_BITS-1:0]        slope_limit_r;

  logic signed [SAMPLE_BITS-1:0]         d_r;
  logic [TIME_BITS-1:0]                  t_r;
  logic [gpd_pkg::INDEX_BITS-1:0]        idx_r;
  logic [gpd_pkg::INDEX_BITS-1:0]        sample_number_r;

  logic                                  region_open_r;
  logic                                  min_found_r;
  logic signed [SAMPLE_BITS-1:0]         run_min_r;
  logic [TIME_BITS-1:0]                  min_time_r;
  logic [gpd_pkg::INDEX_BITS-1:0]        min_index_r;
  logic signed [SAMPLE_BITS-1:0]         first_value_r;
  logic [TIME_BITS-1:0]                  first_time_r;
  logic signed [SB-1:0]                  fall_slope_r;
  logic signed [SB-1:0]                  rise_slope_r;
  logic [gpd_pkg::RISE_BITS-1:0]         rise_count_r;

  // shared divider
  logic [TIME_BITS-1:0]                  rem_r;
  logic [TIME_BITS-1:0]                  dvsr_r;
  logic [NUM_W-1:0]                      quo_r;
  logic [CNT_W-1:0]                      cnt_r;
  logic                                  neg_r;
  logic                                  zero_dt_r;
  logic                                  to_fall_r;

  logic                                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0]         out_value_r;
  logic [TIME_BITS-1:0]                  out_time_r;
  logic [gpd_pkg::INDEX_BITS-1:0]        out_index_r;

  logic                                  in_acc;
  logic                                  d_below, d_above, rise_ok;
  logic                                  take_fall, take_rise, do_judge, peak_ok;
  logic signed [SAMPLE_BITS:0]           diff_sel;
  logic [TIME_BITS-1:0]                  dt_sel;
  logic signed [NUM_W-1:0]               num_s;
  logic [NUM_W-1:0]                      num_mag;
  logic [TIME_BITS:0]                    rem_sh, rem_sub;
  logic                                  q_bit;
  logic signed [EXT_W-1:0]               q_ext;
  logic signed [SB-1:0]                  q_sat;
  logic signed [SB-1:0]                  old_slope;
  logic signed [SB:0]                    avg_sum;
  logic signed [SB-1:0]                  lim_s;
  logic                                  out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != gpd_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // classification of the held item
  assign d_below   = (d_r < run_min_r);
  assign d_above   = (d_r > run_min_r);
  assign rise_ok   = (rise_count_r <= {1'b0, hold_count_r});
  assign take_fall = d_below && region_open_r;
  assign take_rise = !d_below && min_found_r && d_above && rise_ok;
  assign do_judge  = !d_below && min_found_r && d_above && !rise_ok;

  assign lim_s   = SB'(slope_limit_r);
  assign peak_ok = (fall_slope_r <= -lim_s) && (rise_slope_r >= lim_s);

  always_comb begin
    if (take_fall) begin
      diff_sel = (SAMPLE_BITS+1)'(d_r) - (SAMPLE_BITS+1)'(first_value_r);
      dt_sel   = t_r - first_time_r;
    end else begin
      diff_sel = (SAMPLE_BITS+1)'(d_r) - (SAMPLE_BITS+1)'(run_min_r);
      dt_sel   = t_r - min_time_r;
    end
  end

  assign num_s   = {diff_sel, {SLOPE_FRAC_BITS{1'b0}}};
  assign num_mag = diff_sel[SAMPLE_BITS] ? NUM_W'(-num_s) : NUM_W'(num_s);

  // one restoring step per cycle
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_r};
  assign q_bit   = !rem_sub[TIME_BITS];

  always_comb begin
    q_ext = neg_r ? -EXT_W'(quo_r) : EXT_W'(quo_r);
    if (zero_dt_r) begin
      if (neg_r)           q_sat = SL_MIN;
      else if (quo_r != 0) q_sat = SL_MAX;
      else                 q_sat = '0;
    end else if (q_ext > SL_MAX_X) begin
      q_sat = SL_MAX;
    end else if (q_ext < SL_MIN_X) begin
      q_sat = SL_MIN;
    end else begin
      q_sat = SB'(q_ext);
    end
    old_slope = to_fall_r ? fall_slope_r : rise_slope_r;
    avg_sum   = (SB+1)'(old_slope) + (SB+1)'(q_sat);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpd_pkg::ST_IDLE:   if (in_acc) state_nxt = gpd_pkg::ST_DECIDE;
      gpd_pkg::ST_DECIDE: begin
        if (take_fall || take_rise) begin
          state_nxt = (dt_sel == '0) ? gpd_pkg::ST_AVG : gpd_pkg::ST_DIV;
        end else if (do_judge && peak_ok) begin
          state_nxt = gpd_pkg::ST_EMIT;
        end else begin
          state_nxt = gpd_pkg::ST_IDLE;
        end
      end
      gpd_pkg::ST_DIV:    if (cnt_r == '0) state_nxt = gpd_pkg::ST_AVG;
      gpd_pkg::ST_AVG:    state_nxt = gpd_pkg::ST_IDLE;
      gpd_pkg::ST_EMIT:   if (out_free) state_nxt = gpd_pkg::ST_IDLE;
      default:            state_nxt = gpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_floor_r  <= '0;
      hold_count_r  <= gpd_pkg::HOLD_RESET;
      slope_limit_r <= gpd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gpd_pkg::REG_PEAK_FLOOR:  peak_floor_r  <= cfg_data[SAMPLE_BITS-1:0];
        gpd_pkg::REG_HOLD_COUNT:  hold_count_r  <= cfg_data[gpd_pkg::HOLD_BITS-1:0];
        gpd_pkg::REG_SLOPE_LIMIT: slope_limit_r <= cfg_data[gpd_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_number_r <= '0;
      region_open_r   <= 1'b0;
      min_found_r     <= 1'b0;
      run_min_r       <= '0;
      min_time_r      <= '0;
      min_index_r     <= '0;
      first_value_r   <= '0;
      first_time_r    <= '0;
      fall_slope_r    <= '0;
      rise_slope_r    <= '0;
      rise_count_r    <= '0;
    end else begin
      if (in_acc) begin
        sample_number_r <= sample_number_r + 1'b1;
      end
      // floor reload when nothing is tracked
      if (cfg_wr_en && cfg_index == gpd_pkg::REG_PEAK_FLOOR &&
          !min_found_r && !region_open_r) begin
        run_min_r <= cfg_data[SAMPLE_BITS-1:0];
      end
      unique case (state_r)
        gpd_pkg::ST_DECIDE: begin
          if (d_below) begin
            run_min_r   <= d_r;
            min_time_r  <= t_r;
            min_index_r <= idx_r;
            min_found_r <= 1'b1;
            if (!region_open_r) begin
              region_open_r <= 1'b1;
              first_value_r <= d_r;
              first_time_r  <= t_r;
            end
          end else if (take_rise) begin
            rise_count_r <= rise_count_r + 1'b1;
          end else if (do_judge && !peak_ok) begin
            region_open_r <= 1'b0;
            min_found_r   <= 1'b0;
            run_min_r     <= peak_floor_r;
            rise_count_r  <= '0;
            fall_slope_r  <= '0;
            rise_slope_r  <= '0;
          end
        end
        gpd_pkg::ST_AVG: begin
          if (to_fall_r) fall_slope_r <= avg_sum[SB:1];
          else           rise_slope_r <= avg_sum[SB:1];
        end
        gpd_pkg::ST_EMIT: begin
          if (out_free) begin
            region_open_r <= 1'b0;
            min_found_r   <= 1'b0;
            run_min_r     <= peak_floor_r;
            rise_count_r  <= '0;
            fall_slope_r  <= '0;
            rise_slope_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and divider datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r   <= neg_sat(in_sample);
      t_r   <= in_timestamp;
      idx_r <= sample_number_r;
    end
    if (state_r == gpd_pkg::ST_DECIDE) begin
      quo_r     <= num_mag;
      neg_r     <= diff_sel[SAMPLE_BITS];
      dvsr_r    <= dt_sel;
      zero_dt_r <= (dt_sel == '0);
      to_fall_r <= take_fall;
      rem_r     <= '0;
      cnt_r     <= CNT_W'(NUM_W - 1);
    end else if (state_r == gpd_pkg::ST_DIV) begin
      rem_r <= q_bit ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
      quo_r <= {quo_r[NUM_W-2:0], q_bit};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == gpd_pkg::ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gpd_pkg::ST_EMIT && out_free) begin
      out_value_r <= neg_sat(run_min_r);
      out_time_r  <= min_time_r;
      out_index_r <= min_index_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peak_value = out_value_r;
  assign out_peak_time  = out_time_r;
  assign out_peak_index = out_index_r;

endmodule

// ----- hdl/gpd_checker.sv -----
module gpd_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [SAMPLE_BITS-1:0]         out_peak_value,
  input logic        [TIME_BITS-1:0]           out_peak_time,
  input logic        [gpd_pkg::INDEX_BITS-1:0] out_peak_index
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_value) &&
      $stable(out_peak_time) && $stable(out_peak_index))
    else $error("result item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is still in work");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid survived reset");

  // a new peak comes only out of work on an item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind gyro_peak_detector gpd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .TIME_BITS   (TIME_BITS)
) u_gpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_peak_value (out_peak_value),
  .out_peak_time  (out_peak_time),
  .out_peak_index (out_peak_index)
);
